// File: hw/rtl/fea_pkg.sv
`default_nettype none
package fea_pkg;

    localparam int DEF_BITMAP_WORDS = 64;
    localparam int DEF_MAX_EXTENTS  = 64;
    localparam int DEF_MAX_REQUEST  = 64;

    localparam int WORD_BITS   = 64;
    localparam int BIT_IDX_W   = 6;
    localparam int WANT_W      = 7;
    localparam int OUT_BLK_W   = 12;
    localparam int S_DATA_W    = 72;
    localparam int M_DATA_W    = 16;

    localparam logic STATUS_GRANT  = 1'b0;
    localparam logic STATUS_REFUSE = 1'b1;

    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

endpackage
`default_nettype wire

// File: hw/rtl/fea_cell.sv
`default_nettype none
module fea_cell #(
    parameter int BLK_W = 12,
    parameter int LEN_W = 13
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic             ins,
    input  wire logic [BLK_W-1:0] ins_start,
    input  wire logic [LEN_W-1:0] ins_len,
    input  wire logic             prev_keep,
    input  wire logic             prev_valid,
    input  wire logic [BLK_W-1:0] prev_start,
    input  wire logic [LEN_W-1:0] prev_len,
    output logic                  keep,
    output logic                  valid,
    output logic      [BLK_W-1:0] start,
    output logic      [LEN_W-1:0] len,
    input  wire logic             sh_load,
    input  wire logic             sh_shift,
    input  wire logic [BLK_W-1:0] nxt_sh_start,
    input  wire logic [LEN_W-1:0] nxt_sh_len,
    output logic      [BLK_W-1:0] sh_start,
    output logic      [LEN_W-1:0] sh_len
);

    logic             valid_reg;
    logic [BLK_W-1:0] start_reg;
    logic [LEN_W-1:0] len_reg;
    logic [BLK_W-1:0] sh_start_reg;
    logic [LEN_W-1:0] sh_len_reg;

    // An entry holds its place only while it is strictly longer than the newcomer.
    assign keep     = valid_reg && (len_reg > ins_len);
    assign valid    = valid_reg;
    assign start    = start_reg;
    assign len      = len_reg;
    assign sh_start = sh_start_reg;
    assign sh_len   = sh_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ins && !keep && (prev_keep || prev_valid))
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins && !keep)
        begin
            if (prev_keep)
            begin
                start_reg <= ins_start;
                len_reg   <= ins_len;
            end
            else if (prev_valid)
            begin
                start_reg <= prev_start;
                len_reg   <= prev_len;
            end
        end
        if (sh_load)
        begin
            sh_start_reg <= start_reg;
            sh_len_reg   <= len_reg;
        end
        else if (sh_shift)
        begin
            sh_start_reg <= nxt_sh_start;
            sh_len_reg   <= nxt_sh_len;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/fea_chain.sv
`default_nettype none
module fea_chain #(
    parameter int MAX_EXTENTS = 64,
    parameter int BLK_W       = 12,
    parameter int LEN_W       = 13
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic             ins,
    input  wire logic [BLK_W-1:0] ins_start,
    input  wire logic [LEN_W-1:0] ins_len,
    input  wire logic             sh_load,
    input  wire logic             sh_shift,
    output logic      [LEN_W-1:0] free_total,
    output logic      [BLK_W-1:0] head_start,
    output logic      [LEN_W-1:0] head_len,
    output logic      [BLK_W-1:0] sh1_start,
    output logic      [LEN_W-1:0] sh1_len
);

    logic             keep_w     [MAX_EXTENTS];
    logic             valid_w    [MAX_EXTENTS];
    logic [BLK_W-1:0] start_w    [MAX_EXTENTS];
    logic [LEN_W-1:0] len_w      [MAX_EXTENTS];
    logic [BLK_W-1:0] sh_start_w [MAX_EXTENTS];
    logic [LEN_W-1:0] sh_len_w   [MAX_EXTENTS];
    logic [LEN_W-1:0] free_total_reg;

    for (genvar k = 0; k < MAX_EXTENTS; k++)
    begin : g_cell
        logic             p_keep;
        logic             p_valid;
        logic [BLK_W-1:0] p_start;
        logic [LEN_W-1:0] p_len;
        logic [BLK_W-1:0] n_start;
        logic [LEN_W-1:0] n_len;

        if (k == 0)
        begin : g_head
            assign p_keep  = 1'b1;
            assign p_valid = 1'b0;
            assign p_start = '0;
            assign p_len   = '0;
        end
        else
        begin : g_body
            assign p_keep  = keep_w[k-1];
            assign p_valid = valid_w[k-1];
            assign p_start = start_w[k-1];
            assign p_len   = len_w[k-1];
        end

        if (k == MAX_EXTENTS - 1)
        begin : g_tail
            assign n_start = '0;
            assign n_len   = '0;
        end
        else
        begin : g_inner
            assign n_start = sh_start_w[k+1];
            assign n_len   = sh_len_w[k+1];
        end

        fea_cell #(
            .BLK_W (BLK_W),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .clear        (clear),
            .ins          (ins),
            .ins_start    (ins_start),
            .ins_len      (ins_len),
            .prev_keep    (p_keep),
            .prev_valid   (p_valid),
            .prev_start   (p_start),
            .prev_len     (p_len),
            .keep         (keep_w[k]),
            .valid        (valid_w[k]),
            .start        (start_w[k]),
            .len          (len_w[k]),
            .sh_load      (sh_load),
            .sh_shift     (sh_shift),
            .nxt_sh_start (n_start),
            .nxt_sh_len   (n_len),
            .sh_start     (sh_start_w[k]),
            .sh_len       (sh_len_w[k])
        );
    end

    // With a full table the tail entry falls off unless it outranks the newcomer,
    // in which case the newcomer itself is lost.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_total_reg <= '0;
        end
        else if (clear)
        begin
            free_total_reg <= '0;
        end
        else if (ins)
        begin
            if (!valid_w[MAX_EXTENTS-1])
            begin
                free_total_reg <= free_total_reg + ins_len;
            end
            else if (!keep_w[MAX_EXTENTS-1])
            begin
                free_total_reg <= free_total_reg + ins_len - len_w[MAX_EXTENTS-1];
            end
        end
    end

    assign free_total = free_total_reg;
    assign head_start = start_w[0];
    assign head_len   = len_w[0];
    assign sh1_start  = sh_start_w[1];
    assign sh1_len    = sh_len_w[1];

endmodule
`default_nettype wire

// File: hw/rtl/free_extent_allocator_core.sv
`default_nettype none
// A bitmap word is accepted and then scanned one bit per cycle; a word that ends
// a build takes one more step, in ST_FINISH, to close the open run.
// An allocation of n blocks emits n beats back to back, one per cycle while m_tready
// does not stall the output register; a refusal emits one beat.
// Reset clears the extent table valid bits, the free total and the scan state;
// the next bitmap word starts a new build.
module free_extent_allocator_core
    #(
    parameter int BITMAP_WORDS = fea_pkg::DEF_BITMAP_WORDS,
    parameter int MAX_EXTENTS  = fea_pkg::DEF_MAX_EXTENTS,
    parameter int MAX_REQUEST  = fea_pkg::DEF_MAX_REQUEST
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata, low bit up: bitmap_word[63:0], blocks_wanted[70:64], zero pad [71].
    input  wire logic [fea_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: func (0 = bitmap word, 1 = allocation request).
    input  wire logic                          s_tuser,
    // s_tlast: word_last.
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata, low bit up: block_number[11:0], zero pad [15:12].
    output logic      [fea_pkg::M_DATA_W-1:0]  m_tdata,
    // m_tuser: status (0 = granted, 1 = refused).
    output logic                               m_tuser,
    // m_tlast: last beat of the request.
    output logic                               m_tlast
);
    import fea_pkg::*;

    localparam int WI_W  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int BLK_W = WI_W + BIT_IDX_W;
    localparam int LEN_W = $clog2(BITMAP_WORDS * WORD_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_ALLOC,
        ST_REFUSE
    } state_t;

    state_t                 state_reg;
    logic [WORD_BITS-1:0]   word_reg;
    logic [BIT_IDX_W-1:0]   bit_reg;
    logic [WI_W-1:0]        word_idx_reg;
    logic                   end_reg;
    logic                   build_idle_reg;
    logic                   run_open_reg;
    logic [BLK_W-1:0]       run_start_reg;
    logic [LEN_W-1:0]       run_len_reg;
    logic [BLK_W-1:0]       blk_reg;
    logic [LEN_W-1:0]       left_reg;
    logic [WANT_W-1:0]      cnt_reg;
    logic                   m_valid_reg;
    logic [OUT_BLK_W-1:0]   m_blk_reg;
    logic                   m_status_reg;
    logic                   m_last_reg;

    logic                   s_accept;
    logic [WANT_W-1:0]      want;
    logic                   refuse;
    logic                   gen;
    logic                   clear;
    logic                   ins;
    logic [BLK_W-1:0]       ins_start;
    logic [LEN_W-1:0]       ins_len;
    logic                   sh_load;
    logic                   sh_shift;
    logic [LEN_W-1:0]       free_total;
    logic [BLK_W-1:0]       head_start;
    logic [LEN_W-1:0]       head_len;
    logic [BLK_W-1:0]       sh1_start;
    logic [LEN_W-1:0]       sh1_len;
    logic [BLK_W+OUT_BLK_W-1:0] blk_wide;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign want     = s_tdata[WORD_BITS +: WANT_W];

    // Zero, more than is free, or more than one request may take is refused.
    assign refuse = (want == '0)
                 || ({{LEN_W{1'b0}}, want} > {{WANT_W{1'b0}}, free_total})
                 || (want > WANT_W'(MAX_REQUEST));

    // A new result beat is made when the output register is empty or draining.
    assign gen = ((state_reg == ST_ALLOC) || (state_reg == ST_REFUSE))
              && (!m_valid_reg || m_tready);

    assign clear = s_accept && (s_tuser == FUNC_BUILD) && build_idle_reg;

    // A zero bit closes the open run during scan; the final close follows the last word.
    assign ins = run_open_reg
              && (((state_reg == ST_SCAN) && !word_reg[0]) || (state_reg == ST_FINISH));
    assign ins_start = run_start_reg;
    assign ins_len   = run_len_reg;

    // The shadow chain is a snapshot of the table that the grant loop walks head first.
    assign sh_load  = s_accept && (s_tuser == FUNC_ALLOC) && !refuse;
    assign sh_shift = gen && (state_reg == ST_ALLOC) && (left_reg == LEN_W'(1));

    fea_chain #(
        .MAX_EXTENTS (MAX_EXTENTS),
        .BLK_W       (BLK_W),
        .LEN_W       (LEN_W)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .ins        (ins),
        .ins_start  (ins_start),
        .ins_len    (ins_len),
        .sh_load    (sh_load),
        .sh_shift   (sh_shift),
        .free_total (free_total),
        .head_start (head_start),
        .head_len   (head_len),
        .sh1_start  (sh1_start),
        .sh1_len    (sh1_len)
    );

    assign blk_wide = {{OUT_BLK_W{1'b0}}, blk_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            word_idx_reg   <= '0;
            build_idle_reg <= 1'b1;
            run_open_reg   <= 1'b0;
            run_len_reg    <= '0;
            run_start_reg  <= '0;
            m_valid_reg    <= 1'b0;
            bit_reg        <= '0;
            end_reg        <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (gen)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        if (s_tuser == FUNC_BUILD)
                        begin
                            word_reg  <= s_tdata[WORD_BITS-1:0];
                            bit_reg   <= '0;
                            state_reg <= ST_SCAN;
                            if (build_idle_reg)
                            begin
                                word_idx_reg   <= '0;
                                run_open_reg   <= 1'b0;
                                run_len_reg    <= '0;
                                build_idle_reg <= 1'b0;
                                end_reg <= s_tlast || (BITMAP_WORDS == 1);
                            end
                            else
                            begin
                                end_reg <= s_tlast
                                        || (word_idx_reg == WI_W'(BITMAP_WORDS - 1));
                            end
                        end
                        else if (refuse)
                        begin
                            state_reg <= ST_REFUSE;
                        end
                        else
                        begin
                            blk_reg   <= head_start;
                            left_reg  <= head_len;
                            cnt_reg   <= want;
                            state_reg <= ST_ALLOC;
                        end
                    end
                end
                ST_SCAN:
                begin
                    word_reg <= word_reg >> 1;
                    bit_reg  <= bit_reg + BIT_IDX_W'(1);
                    if (word_reg[0])
                    begin
                        if (!run_open_reg)
                        begin
                            run_open_reg  <= 1'b1;
                            run_start_reg <= {word_idx_reg, bit_reg};
                            run_len_reg   <= LEN_W'(1);
                        end
                        else
                        begin
                            run_len_reg <= run_len_reg + LEN_W'(1);
                        end
                    end
                    else
                    begin
                        run_open_reg <= 1'b0;
                        run_len_reg  <= '0;
                    end
                    if (bit_reg == BIT_IDX_W'(WORD_BITS - 1))
                    begin
                        if (end_reg)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            word_idx_reg <= word_idx_reg + WI_W'(1);
                            state_reg    <= ST_IDLE;
                        end
                    end
                end
                ST_FINISH:
                begin
                    run_open_reg   <= 1'b0;
                    run_len_reg    <= '0;
                    build_idle_reg <= 1'b1;
                    word_idx_reg   <= '0;
                    state_reg      <= ST_IDLE;
                end
                ST_ALLOC:
                begin
                    if (gen)
                    begin
                        m_blk_reg    <= blk_wide[OUT_BLK_W-1:0];
                        m_status_reg <= STATUS_GRANT;
                        m_last_reg   <= (cnt_reg == WANT_W'(1));
                        cnt_reg      <= cnt_reg - WANT_W'(1);
                        if (left_reg == LEN_W'(1))
                        begin
                            blk_reg  <= sh1_start;
                            left_reg <= sh1_len;
                        end
                        else
                        begin
                            blk_reg  <= blk_reg + BLK_W'(1);
                            left_reg <= left_reg - LEN_W'(1);
                        end
                        if (cnt_reg == WANT_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_REFUSE:
                begin
                    if (gen)
                    begin
                        m_blk_reg    <= '0;
                        m_status_reg <= STATUS_REFUSE;
                        m_last_reg   <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - OUT_BLK_W){1'b0}}, m_blk_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    a_refuse_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STATUS_REFUSE)) |-> m_tlast)
        else $error("refusal beat without last");

    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC) |-> (left_reg != '0))
        else $error("grant loop walked into an empty extent");

    a_build_clears: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (free_total == '0))
        else $error("free total not cleared at build start");

    a_no_insert_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ALLOC) || (state_reg == ST_REFUSE)) |-> !ins)
        else $error("table changed during allocation");

endmodule
`default_nettype wire
